// ===== design/gha_pkg.sv =====
package gha_pkg;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_GET    = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HANDLE = 2'd1,
        ST_FULL       = 2'd2,
        ST_NULL       = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP,
        S_BUMP,
        S_CHECK
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic    capture;
        logic    sel_popped;
        logic    pop_take;
        logic    alloc_fresh;
        logic    alloc_reuse;
        logic    release_slot;
        logic    fetch;
        logic    finish;
        t_status fin_status;
    } t_ctl;

    // status from datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic is_null;
        logic has_free;
        logic has_fresh;
        logic pre_ok;
        logic slot_ok;
    } t_stat;

endpackage

// ===== design/gha_ram.sv =====
module gha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/gha_ctrl.sv =====
module gha_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  gha_pkg::t_stat i_stat,
    output gha_pkg::t_ctl  o_ctl,
    output logic           o_busy
);

    gha_pkg::t_state r_state;
    gha_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gha_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gha_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = gha_pkg::S_DISPATCH;
                end
            end
            gha_pkg::S_DISPATCH: begin
                n_state = gha_pkg::S_IDLE;
                case (i_stat.cmd) inside
                    gha_pkg::CMD_ADD: begin
                        if (!i_stat.is_null && i_stat.has_free) begin
                            n_state = gha_pkg::S_POP;
                        end
                    end
                    gha_pkg::CMD_REMOVE, gha_pkg::CMD_GET: begin
                        if (i_stat.pre_ok) begin
                            n_state = gha_pkg::S_CHECK;
                        end
                    end
                    default: begin
                        n_state = gha_pkg::S_IDLE;
                    end
                endcase
            end
            gha_pkg::S_POP:   n_state = gha_pkg::S_BUMP;
            gha_pkg::S_BUMP:  n_state = gha_pkg::S_IDLE;
            gha_pkg::S_CHECK: n_state = gha_pkg::S_IDLE;
            default:          n_state = gha_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctl            = '0;
        o_ctl.fin_status = gha_pkg::ST_OK;
        unique case (r_state)
            gha_pkg::S_IDLE: begin
                o_ctl.capture = i_start;
            end
            gha_pkg::S_DISPATCH: begin
                case (i_stat.cmd) inside
                    gha_pkg::CMD_ADD: begin
                        if (i_stat.is_null) begin
                            o_ctl.finish     = 1'b1;
                            o_ctl.fin_status = gha_pkg::ST_NULL;
                        end else if (i_stat.has_free) begin
                            o_ctl.finish = 1'b0;
                        end else if (i_stat.has_fresh) begin
                            o_ctl.alloc_fresh = 1'b1;
                            o_ctl.finish      = 1'b1;
                        end else begin
                            o_ctl.finish     = 1'b1;
                            o_ctl.fin_status = gha_pkg::ST_FULL;
                        end
                    end
                    gha_pkg::CMD_REMOVE, gha_pkg::CMD_GET: begin
                        if (!i_stat.pre_ok) begin
                            o_ctl.finish     = 1'b1;
                            o_ctl.fin_status = gha_pkg::ST_BAD_HANDLE;
                        end
                    end
                    default: begin
                        o_ctl.finish     = 1'b1;
                        o_ctl.fin_status = gha_pkg::ST_BAD_HANDLE;
                    end
                endcase
            end
            gha_pkg::S_POP: begin
                o_ctl.pop_take   = 1'b1;
                o_ctl.sel_popped = 1'b1;
            end
            gha_pkg::S_BUMP: begin
                o_ctl.alloc_reuse = 1'b1;
                o_ctl.finish      = 1'b1;
            end
            gha_pkg::S_CHECK: begin
                o_ctl.finish = 1'b1;
                if (!i_stat.slot_ok) begin
                    o_ctl.fin_status = gha_pkg::ST_BAD_HANDLE;
                end else if (i_stat.cmd == gha_pkg::CMD_REMOVE) begin
                    o_ctl.release_slot = 1'b1;
                end else begin
                    o_ctl.fetch = 1'b1;
                end
            end
            default: begin
                o_ctl.finish = 1'b0;
            end
        endcase
    end

    assign o_busy = (r_state != gha_pkg::S_IDLE);

endmodule

// ===== design/gha_dpath.sv =====
module gha_dpath #(
    parameter int SLOT_COUNT   = 256,
    parameter int GEN_BITS     = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  gha_pkg::t_ctl                    i_ctl,
    output gha_pkg::t_stat                   o_stat,
    input  logic [1:0]                       i_cmd,
    input  logic [PAYLOAD_BITS-1:0]          i_payload_in,
    input  logic [$clog2(SLOT_COUNT)-1:0]    i_req_index,
    input  logic [GEN_BITS-1:0]              i_req_generation,
    output logic                             o_done,
    output logic [1:0]                       o_status,
    output logic [$clog2(SLOT_COUNT)-1:0]    o_out_index,
    output logic [GEN_BITS-1:0]              o_out_generation,
    output logic [PAYLOAD_BITS-1:0]          o_out_payload,
    output logic [$clog2(SLOT_COUNT+1)-1:0]  o_live_count
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int SW    = 1 + GEN_BITS + PAYLOAD_BITS;
    localparam logic [GEN_BITS-1:0] GEN_FIRST = GEN_BITS'(1);
    localparam logic [GEN_BITS-1:0] GEN_LAST  = {GEN_BITS{1'b1}};
    localparam logic [CNT_W-1:0]    CNT_SLOTS = CNT_W'(SLOT_COUNT);

    // captured request
    gha_pkg::t_cmd             r_cmd;
    logic [PAYLOAD_BITS-1:0]   r_payload;
    logic [IDX_W-1:0]          r_req_index;
    logic [GEN_BITS-1:0]       r_req_gen;
    logic [IDX_W-1:0]          r_slot;

    // allocator counters
    logic [CNT_W-1:0]          r_free_depth;
    logic [CNT_W-1:0]          r_next_fresh;
    logic [CNT_W-1:0]          r_live;
    logic [CNT_W-1:0]          n_live;

    // result registers
    logic                      r_done;
    gha_pkg::t_status          r_status;
    logic [IDX_W-1:0]          r_out_index;
    logic [GEN_BITS-1:0]       r_out_gen;
    logic [PAYLOAD_BITS-1:0]   r_out_payload;
    logic [CNT_W-1:0]          r_out_live;

    // memory ports
    logic                      slot_we;
    logic [IDX_W-1:0]          slot_waddr;
    logic [SW-1:0]             slot_wdata;
    logic [IDX_W-1:0]          slot_raddr;
    logic [SW-1:0]             slot_rdata;
    logic                      rd_in_use;
    logic [GEN_BITS-1:0]       rd_gen;
    logic [PAYLOAD_BITS-1:0]   rd_payload;
    logic [GEN_BITS-1:0]       gen_bumped;
    logic [CNT_W-1:0]          depth_m1;
    logic [IDX_W-1:0]          fs_rdata;

    assign {rd_in_use, rd_gen, rd_payload} = slot_rdata;

    // generation wraps past zero to one
    assign gen_bumped = (rd_gen == GEN_LAST) ? GEN_FIRST : rd_gen + GEN_FIRST;
    assign depth_m1   = r_free_depth - CNT_W'(1);

    assign slot_raddr = i_ctl.sel_popped ? fs_rdata : r_req_index;
    assign slot_we    = i_ctl.alloc_fresh | i_ctl.alloc_reuse | i_ctl.release_slot;

    always_comb begin
        if (i_ctl.alloc_fresh) begin
            slot_waddr = r_next_fresh[IDX_W-1:0];
            slot_wdata = {1'b1, GEN_FIRST, r_payload};
        end else if (i_ctl.alloc_reuse) begin
            slot_waddr = r_slot;
            slot_wdata = {1'b1, gen_bumped, r_payload};
        end else begin
            slot_waddr = r_req_index;
            slot_wdata = {1'b0, rd_gen, rd_payload};
        end
    end

    always_comb begin
        n_live = r_live;
        if (i_ctl.alloc_fresh || i_ctl.alloc_reuse) begin
            n_live = r_live + CNT_W'(1);
        end else if (i_ctl.release_slot) begin
            n_live = r_live - CNT_W'(1);
        end
    end

    gha_ram #(
        .WIDTH (SW),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    gha_ram #(
        .WIDTH (IDX_W),
        .DEPTH (SLOT_COUNT)
    ) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.release_slot),
        .i_waddr (r_free_depth[IDX_W-1:0]),
        .i_wdata (r_req_index),
        .i_raddr (depth_m1[IDX_W-1:0]),
        .o_rdata (fs_rdata)
    );

    // request capture and popped slot
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd       <= gha_pkg::t_cmd'(i_cmd);
            r_payload   <= i_payload_in;
            r_req_index <= i_req_index;
            r_req_gen   <= i_req_generation;
        end
        if (i_ctl.pop_take) begin
            r_slot <= fs_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_depth <= '0;
            r_next_fresh <= '0;
            r_live       <= '0;
            r_done       <= 1'b0;
        end else begin
            r_live <= n_live;
            r_done <= i_ctl.finish;
            if (i_ctl.alloc_fresh) begin
                r_next_fresh <= r_next_fresh + CNT_W'(1);
            end
            if (i_ctl.pop_take) begin
                r_free_depth <= depth_m1;
            end else if (i_ctl.release_slot) begin
                r_free_depth <= r_free_depth + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_status   <= i_ctl.fin_status;
            r_out_live <= n_live;
            if (i_ctl.alloc_fresh) begin
                r_out_index <= r_next_fresh[IDX_W-1:0];
                r_out_gen   <= GEN_FIRST;
            end else if (i_ctl.alloc_reuse) begin
                r_out_index <= r_slot;
                r_out_gen   <= gen_bumped;
            end else begin
                r_out_index <= '0;
                r_out_gen   <= '0;
            end
            r_out_payload <= i_ctl.fetch ? rd_payload : '0;
        end
    end

    assign o_stat.cmd       = r_cmd;
    assign o_stat.is_null   = (r_payload == '0);
    assign o_stat.has_free  = (r_free_depth != '0);
    assign o_stat.has_fresh = (r_next_fresh < CNT_SLOTS);
    assign o_stat.pre_ok    = (r_req_gen != '0) && (CNT_W'(r_req_index) < r_next_fresh);
    assign o_stat.slot_ok   = rd_in_use && (rd_gen == r_req_gen);

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_out_index      = r_out_index;
    assign o_out_generation = r_out_gen;
    assign o_out_payload    = r_out_payload;
    assign o_live_count     = r_out_live;

endmodule

// ===== design/generational_handle_allocator.sv =====
// result strobe o_done is registered from the last state: dispatch for add of a fresh slot,
// null, full, bad handle or undefined command, check for a checked get or remove, bump for an
// add that reuses a freed slot (free stack read, then slot read, each a registered port)
// a new item is taken only back in idle; busy is high while an item is in flight
// results are never stalled; reset (synchronous, active low) empties the table at once
module generational_handle_allocator #(
    parameter int SLOT_COUNT   = 256,
    parameter int GEN_BITS     = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       i_cmd,
    input  logic [PAYLOAD_BITS-1:0]          i_payload_in,
    input  logic [$clog2(SLOT_COUNT)-1:0]    i_req_index,
    input  logic [GEN_BITS-1:0]              i_req_generation,
    output logic                             o_done,
    output logic [1:0]                       o_status,
    output logic [$clog2(SLOT_COUNT)-1:0]    o_out_index,
    output logic [GEN_BITS-1:0]              o_out_generation,
    output logic [PAYLOAD_BITS-1:0]          o_out_payload,
    output logic [$clog2(SLOT_COUNT+1)-1:0]  o_live_count
);

    // the slot table holds {in use, generation, payload} per slot; entries at or above
    // the fresh pointer were never taken, so no clearing pass is needed: a fresh slot is
    // written with generation one and handles above the pointer are rejected up front
    // the free stack is a second ram, pushed on remove and popped on add (lifo reuse)

    gha_pkg::t_ctl  ctl;
    gha_pkg::t_stat stat;

    // item accepted when start is seen in idle
    gha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    // counters, slot and free stack rams, result registers
    gha_dpath #(
        .SLOT_COUNT   (SLOT_COUNT),
        .GEN_BITS     (GEN_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .o_stat           (stat),
        .i_cmd            (i_cmd),
        .i_payload_in     (i_payload_in),
        .i_req_index      (i_req_index),
        .i_req_generation (i_req_generation),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_out_index      (o_out_index),
        .o_out_generation (o_out_generation),
        .o_out_payload    (o_out_payload),
        .o_live_count     (o_live_count)
    );

endmodule
